### rtl/core/sds_pkg.sv
// Shared types and constants of the SCAN disk scheduler.
package sds_pkg;

	localparam int MAX_REQUESTS_DEF = 32;

	localparam int TRACK_W = 16;
	localparam int TOTAL_W = 22;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP    = 2'd2;

	localparam logic [15:0] START_HEAD_RST  = 16'd0;
	localparam logic [16:0] TRACK_COUNT_RST = 17'd200;
	localparam logic        SWEEP_UP_RST    = 1'b1;

	typedef struct packed {
		logic [TRACK_W-1:0] track;
		logic               last;
	} req_t;

	typedef struct packed {
		logic [TRACK_W-1:0] served_track;
		logic [TRACK_W-1:0] prior_head;
		logic [TRACK_W-1:0] seek_distance;
		logic [TOTAL_W-1:0] total_seek;
		logic               overflowed;
		logic               final_res;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_PLAN,
		ST_EMIT_RD,
		ST_EMIT_OUT,
		ST_EDGE
	} st_t;

endpackage

### rtl/core/scan_disk_scheduler.sv
// SCAN (elevator) disk scheduler: request store, rank sort and sweep emission.
// A request without last is taken while idle; requests load back to back.
// A last request starts the schedule: a rank sort over the store (a read and a
// compare state per pair of store entries), a planning state, then a read and an
// output state per served request and an edge state for the edge visit; busy is
// high throughout, results leave one per strobe and the receiver cannot stall them.
module scan_disk_scheduler #(
	parameter int MAX_REQUESTS = sds_pkg::MAX_REQUESTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  sds_pkg::req_t                       req,
	input  logic                                cfg_we,
	input  logic [sds_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [sds_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output logic                                res_valid,
	output sds_pkg::res_t                       res
);

	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
	localparam int TW = sds_pkg::TRACK_W;
	localparam int SW = sds_pkg::TOTAL_W;

	sds_pkg::st_t state_q, state_d;

	logic [TW-1:0] start_head_q;
	logic [16:0]   track_count_q;
	logic          sweep_up_q;

	logic [CNT_W-1:0] count_q, count_d;
	logic             drop_q, drop_d;
	logic [IDX_W-1:0] i_q, i_d, j_q, j_d, rank_q, rank_d, rank_nx;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [IDX_W-1:0] ptr_q, ptr_d;
	logic             up_q, up_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             in_b_q, in_b_d;
	logic [TW-1:0]    head_q, head_d;
	logic [SW-1:0]    total_q, total_d;

	logic [TW-1:0] store_mem [MAX_REQUESTS];
	logic [TW-1:0] sort_mem [MAX_REQUESTS];
	logic [TW-1:0] rda_q, rdb_q, srt_rd_q;
	logic          store_we, srt_we;

	logic          res_valid_q, res_valid_d;
	sds_pkg::res_t res_q, res_d;

	logic [16:0]      tc_m1;
	logic [TW-1:0]    edge_trk;
	logic [CNT_W-1:0] n_m1, n_hi, b_cnt, pos_m1;
	logic             hit;
	logic [TW-1:0]    seek_d;
	logic [SW-1:0]    tot;

	function automatic logic [TW-1:0] abs_diff(input logic [TW-1:0] a, input logic [TW-1:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

	assign busy = (state_q != sds_pkg::ST_IDLE);
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_head_q  <= sds_pkg::START_HEAD_RST;
			track_count_q <= sds_pkg::TRACK_COUNT_RST;
			sweep_up_q    <= sds_pkg::SWEEP_UP_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				sds_pkg::CFG_START_HEAD:  start_head_q  <= cfg_wdata[TW-1:0];
				sds_pkg::CFG_TRACK_COUNT: track_count_q <= cfg_wdata[16:0];
				sds_pkg::CFG_SWEEP_UP:    sweep_up_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		tc_m1 = track_count_q - 17'd1;
		if (!sweep_up_q || track_count_q == 17'd0)
			edge_trk = '0;
		else if (tc_m1[16])
			edge_trk = '1;
		else
			edge_trk = tc_m1[TW-1:0];
	end

	always_ff @(posedge clk) begin
		if (store_we)
			store_mem[count_q[IDX_W-1:0]] <= req.track;
		rda_q <= store_mem[i_q];
		rdb_q <= store_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (srt_we)
			sort_mem[rank_nx] <= rda_q;
		srt_rd_q <= sort_mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sds_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		drop_d      = drop_q;
		i_d         = i_q;
		j_d         = j_q;
		rank_d      = rank_q;
		pos_d       = pos_q;
		ptr_d       = ptr_q;
		up_d        = up_q;
		cnt_d       = cnt_q;
		in_b_d      = in_b_q;
		head_d      = head_q;
		total_d     = total_q;
		store_we    = 1'b0;
		srt_we      = 1'b0;
		res_valid_d = 1'b0;
		res_d       = res_q;

		n_m1   = count_q - CNT_W'(1);
		n_hi   = count_q - pos_q;
		pos_m1 = pos_q - CNT_W'(1);
		b_cnt  = sweep_up_q ? pos_q : n_hi;
		hit    = (rdb_q < rda_q) || ((rdb_q == rda_q) && (j_q < i_q));
		rank_nx = rank_q + IDX_W'(hit);
		seek_d = '0;
		tot    = total_q;

		case (state_q)
			sds_pkg::ST_IDLE: begin
				if (start) begin
					if (count_q < CNT_W'(MAX_REQUESTS)) begin
						store_we = 1'b1;
						count_d  = count_q + CNT_W'(1);
					end else begin
						drop_d = 1'b1;
					end
					if (req.last) begin
						state_d = sds_pkg::ST_RD;
						i_d     = '0;
						j_d     = '0;
						rank_d  = '0;
						pos_d   = '0;
					end
				end
			end
			sds_pkg::ST_RD: state_d = sds_pkg::ST_CMP;
			sds_pkg::ST_CMP: begin
				if (CNT_W'(j_q) == n_m1) begin
					srt_we = 1'b1;
					pos_d  = pos_q + CNT_W'(rda_q <= start_head_q);
					j_d    = '0;
					rank_d = '0;
					if (CNT_W'(i_q) == n_m1) begin
						state_d = sds_pkg::ST_PLAN;
					end else begin
						i_d     = i_q + IDX_W'(1);
						state_d = sds_pkg::ST_RD;
					end
				end else begin
					j_d     = j_q + IDX_W'(1);
					rank_d  = rank_nx;
					state_d = sds_pkg::ST_RD;
				end
			end
			sds_pkg::ST_PLAN: begin
				head_d  = start_head_q;
				total_d = '0;
				in_b_d  = 1'b0;
				if (sweep_up_q) begin
					ptr_d = pos_q[IDX_W-1:0];
					up_d  = 1'b1;
					cnt_d = n_hi;
				end else begin
					ptr_d = pos_m1[IDX_W-1:0];
					up_d  = 1'b0;
					cnt_d = pos_q;
				end
				if ((sweep_up_q ? n_hi : pos_q) == '0)
					state_d = sds_pkg::ST_EDGE;
				else
					state_d = sds_pkg::ST_EMIT_RD;
			end
			sds_pkg::ST_EMIT_RD: state_d = sds_pkg::ST_EMIT_OUT;
			sds_pkg::ST_EMIT_OUT: begin
				seek_d = abs_diff(srt_rd_q, head_q);
				tot  = total_q + SW'(seek_d);
				res_valid_d         = 1'b1;
				res_d.served_track  = srt_rd_q;
				res_d.prior_head    = head_q;
				res_d.seek_distance = seek_d;
				res_d.total_seek    = tot;
				res_d.overflowed    = drop_q;
				if (in_b_q)
					res_d.final_res = (cnt_q == CNT_W'(1));
				else
					res_d.final_res = (cnt_q == CNT_W'(1)) && (srt_rd_q == edge_trk)
						&& (b_cnt == '0);
				head_d  = srt_rd_q;
				total_d = tot;
				cnt_d   = cnt_q - CNT_W'(1);
				ptr_d   = up_q ? (ptr_q + IDX_W'(1)) : (ptr_q - IDX_W'(1));
				if (cnt_q == CNT_W'(1)) begin
					if (in_b_q) begin
						state_d = sds_pkg::ST_IDLE;
						count_d = '0;
						drop_d  = 1'b0;
					end else begin
						state_d = sds_pkg::ST_EDGE;
					end
				end else begin
					state_d = sds_pkg::ST_EMIT_RD;
				end
			end
			sds_pkg::ST_EDGE: begin
				if (head_q != edge_trk) begin
					seek_d = abs_diff(edge_trk, head_q);
					tot  = total_q + SW'(seek_d);
					res_valid_d         = 1'b1;
					res_d.served_track  = edge_trk;
					res_d.prior_head    = head_q;
					res_d.seek_distance = seek_d;
					res_d.total_seek    = tot;
					res_d.overflowed    = drop_q;
					res_d.final_res     = (b_cnt == '0);
					head_d  = edge_trk;
					total_d = tot;
				end
				in_b_d = 1'b1;
				if (sweep_up_q) begin
					ptr_d = pos_m1[IDX_W-1:0];
					up_d  = 1'b0;
				end else begin
					ptr_d = pos_q[IDX_W-1:0];
					up_d  = 1'b1;
				end
				cnt_d = b_cnt;
				if (b_cnt == '0) begin
					state_d = sds_pkg::ST_IDLE;
					count_d = '0;
					drop_d  = 1'b0;
				end else begin
					state_d = sds_pkg::ST_EMIT_RD;
				end
			end
			default: state_d = sds_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			drop_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			count_q     <= count_d;
			drop_q      <= drop_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q     <= i_d;
		j_q     <= j_d;
		rank_q  <= rank_d;
		pos_q   <= pos_d;
		ptr_q   <= ptr_d;
		up_q    <= up_d;
		cnt_q   <= cnt_d;
		in_b_q  <= in_b_d;
		head_q  <= head_d;
		total_q <= total_d;
		res_q   <= res_d;
	end

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_REQUESTS))
		else $error("request count beyond store depth");

	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $past(busy))
		else $error("result strobe without a running schedule");

	a_final_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.final_res) |=> !res_valid)
		else $error("result after the final transfer");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sds_pkg::ST_EMIT_OUT || state_q == sds_pkg::ST_EDGE) |-> pos_q <= count_q)
		else $error("split point beyond request count");
`endif

endmodule

### bench/testbench.sv
// Self-checking bench for the SCAN disk scheduler: directed rows, then random request batches.
module testbench;

	localparam int SLOTS = sds_pkg::MAX_REQUESTS_DEF;
	localparam int RANDOM_ITEMS = 305;
	localparam int QUIET_LIMIT = 10000;
	localparam int TAIL_CYCLES = 200;
	localparam int DIRECTED_ROWS = 33;
	localparam logic [sds_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic                           is_write;
		logic [sds_pkg::CFG_IDX_W-1:0]  idx;
		logic [sds_pkg::CFG_DATA_W-1:0] data;
		sds_pkg::req_t                  item;
		logic [1:0]                     n_typed;
		sds_pkg::res_t                  typed0;
		sds_pkg::res_t                  typed1;
	} step_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           start = 1'b0;
	logic                           busy;
	sds_pkg::req_t                  req = '0;
	logic                           cfg_we = 1'b0;
	logic [sds_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [sds_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                           res_valid;
	sds_pkg::res_t                  res;

	// predictor state
	logic [15:0]   held_tracks [SLOTS];
	int            held_count = 0;
	logic          lost_batch = 1'b0;
	logic [15:0]   cfg_head = sds_pkg::START_HEAD_RST;
	logic [16:0]   cfg_tracks = sds_pkg::TRACK_COUNT_RST;
	logic          cfg_up = sds_pkg::SWEEP_UP_RST;
	logic [15:0]   walk_head;
	int unsigned   walk_total;
	sds_pkg::res_t sweep_visits [$];
	sds_pkg::res_t expected_visits [$];
	int            mismatch_count = 0;
	sds_pkg::res_t want;
	step_row_t     directed_rows [DIRECTED_ROWS];

	always #2 clk = ~clk;

	scan_disk_scheduler dut (
		.clk,
		.arst_n,
		.start,
		.busy,
		.req,
		.cfg_we,
		.cfg_idx,
		.cfg_wdata,
		.res_valid,
		.res
	);

	function automatic int unsigned disk_top();
		int unsigned top;
		top = (cfg_tracks == 0) ? 0 : cfg_tracks - 1;
		if (top > 65535) top = 65535;
		return top;
	endfunction

	function automatic void add_visit(logic [15:0] trk);
		sds_pkg::res_t v;
		int unsigned d;
		d = 32'((trk > walk_head) ? trk - walk_head : walk_head - trk);
		walk_total = walk_total + d;
		v.served_track = trk;
		v.prior_head = walk_head;
		v.seek_distance = d[15:0];
		v.total_seek = walk_total[sds_pkg::TOTAL_W-1:0];
		v.overflowed = lost_batch;
		v.final_res = 1'b0;
		sweep_visits.push_back(v);
		walk_head = trk;
	endfunction

	// stores the request; on last, builds the whole visit list of the sweep
	function automatic void take_request(sds_pkg::req_t r);
		logic [15:0] order [SLOTS];
		logic [15:0] v;
		logic [15:0] edge_trk;
		int n, pos, i, j;
		sweep_visits.delete();
		if (held_count < SLOTS) begin
			held_tracks[held_count] = r.track;
			held_count++;
		end else begin
			lost_batch = 1'b1;
		end
		if (!r.last) return;
		n = held_count;
		for (i = 0; i < n; i++) order[i] = held_tracks[i];
		for (i = 1; i < n; i++) begin
			v = order[i];
			j = i;
			while (j > 0 && order[j-1] > v) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = v;
		end
		pos = n;
		for (i = n - 1; i >= 0; i--) if (order[i] > cfg_head) pos = i;
		edge_trk = cfg_up ? 16'(disk_top()) : 16'd0;
		walk_head = cfg_head;
		walk_total = 0;
		if (cfg_up) begin
			for (i = pos; i < n; i++) add_visit(order[i]);
		end else begin
			for (i = pos; i > 0; i--) add_visit(order[i-1]);
		end
		if (walk_head != edge_trk) add_visit(edge_trk);
		if (cfg_up) begin
			for (i = pos; i > 0; i--) add_visit(order[i-1]);
		end else begin
			for (i = pos; i < n; i++) add_visit(order[i]);
		end
		sweep_visits[sweep_visits.size() - 1].final_res = 1'b1;
		held_count = 0;
		lost_batch = 1'b0;
	endfunction

	function automatic sds_pkg::res_t visit(int unsigned trk, int unsigned prior,
			int unsigned step_dist, int unsigned total, int unsigned ovf, int unsigned fin);
		sds_pkg::res_t v;
		v.served_track = trk[15:0];
		v.prior_head = prior[15:0];
		v.seek_distance = step_dist[15:0];
		v.total_seek = total[sds_pkg::TOTAL_W-1:0];
		v.overflowed = ovf[0];
		v.final_res = fin[0];
		return v;
	endfunction

	function automatic step_row_t reg_row(logic [sds_pkg::CFG_IDX_W-1:0] idx,
			logic [sds_pkg::CFG_DATA_W-1:0] val);
		step_row_t r;
		r = '0;
		r.is_write = 1'b1;
		r.idx = idx;
		r.data = val;
		return r;
	endfunction

	function automatic step_row_t req_row(logic [15:0] trk, logic lst);
		step_row_t r;
		r = '0;
		r.item.track = trk;
		r.item.last = lst;
		return r;
	endfunction

	function automatic step_row_t known_row(logic [15:0] trk, logic [1:0] n, sds_pkg::res_t a,
			sds_pkg::res_t b);
		step_row_t r;
		r = req_row(trk, 1'b1);
		r.n_typed = n;
		r.typed0 = a;
		r.typed1 = b;
		return r;
	endfunction

	function automatic logic [15:0] pick_track(logic [15:0] prev);
		case ($urandom_range(0, 9))
			0, 1, 2: return 16'($urandom_range(0, 65535));
			3: return cfg_head;
			4: return 16'(disk_top());
			5: return prev;
			6: return $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
			default: return 16'($urandom_range(0, disk_top()));
		endcase
	endfunction

	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 40) $display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic send_request(sds_pkg::req_t r, logic typed);
		logic taken;
		start <= 1'b1;
		req <= r;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		take_request(r);
		if (!typed) foreach (sweep_visits[i]) expected_visits.push_back(sweep_visits[i]);
	endtask

	task automatic send_gap(int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// sender holds off until every visit is in and the block is idle
	task automatic settle();
		logic idle;
		start <= 1'b0;
		while (expected_visits.size() != 0) @(posedge clk);
		do begin
			@(negedge clk);
			idle = !busy;
			@(posedge clk);
		end while (!idle);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [sds_pkg::CFG_IDX_W-1:0] idx,
			logic [sds_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sds_pkg::CFG_START_HEAD: cfg_head = val[15:0];
			sds_pkg::CFG_TRACK_COUNT: cfg_tracks = val;
			sds_pkg::CFG_SWEEP_UP: cfg_up = val[0];
			default: ;
		endcase
	endtask

	task automatic shuffle_registers();
		logic [sds_pkg::CFG_DATA_W-1:0] val;
		if ($urandom_range(0, 1)) begin
			case ($urandom_range(0, 3))
				0: val = '0;
				1: val = 17'hFFFF;
				2: val = 17'($urandom_range(0, disk_top()));
				default: val = 17'($urandom_range(0, 17'h1FFFF));
			endcase
			write_reg(sds_pkg::CFG_START_HEAD, val);
		end
		if ($urandom_range(0, 1)) begin
			case ($urandom_range(0, 6))
				0: val = '0;
				1: val = 17'd1;
				2: val = 17'd200;
				3: val = 17'h10000;
				4: val = 17'h1FFFF;
				5: val = 17'($urandom_range(2, 600));
				default: val = 17'($urandom_range(0, 17'h1FFFF));
			endcase
			write_reg(sds_pkg::CFG_TRACK_COUNT, val);
		end
		if ($urandom_range(0, 1))
			write_reg(sds_pkg::CFG_SWEEP_UP, 17'($urandom_range(0, 17'h1FFFF)));
		if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, 17'($urandom_range(0, 17'h1FFFF)));
	endtask

	always @(negedge clk) begin
		if (arst_n && res_valid) begin
			if (expected_visits.size() == 0) begin
				report_mismatch($sformatf("visit to track %0d with none pending",
					res.served_track));
			end else begin
				want = expected_visits.pop_front();
				if (res.served_track !== want.served_track)
					report_mismatch($sformatf("served_track %0d, want %0d",
						res.served_track, want.served_track));
				if (res.prior_head !== want.prior_head)
					report_mismatch($sformatf("prior_head %0d, want %0d",
						res.prior_head, want.prior_head));
				if (res.seek_distance !== want.seek_distance)
					report_mismatch($sformatf("seek_distance %0d, want %0d",
						res.seek_distance, want.seek_distance));
				if (res.total_seek !== want.total_seek)
					report_mismatch($sformatf("total_seek %0d, want %0d",
						res.total_seek, want.total_seek));
				if (res.overflowed !== want.overflowed)
					report_mismatch($sformatf("overflowed %b, want %b",
						res.overflowed, want.overflowed));
				if (res.final_res !== want.final_res)
					report_mismatch($sformatf("final_res %b, want %b",
						res.final_res, want.final_res));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if ((start && !busy) || res_valid) quiet = 0;
			else quiet++;
		end
		$display("testbench: done, errors");
		$finish;
	end

	initial begin : stimulus
		int sent, batch, len, k;
		logic burst;
		logic [15:0] trk;
		step_row_t rw;
		sds_pkg::req_t r;

		directed_rows = '{
			known_row(16'd50, 2'd2, visit(50, 0, 50, 50, 0, 0), visit(199, 50, 149, 199, 0, 1)),
			known_row(16'd0, 2'd2, visit(199, 0, 199, 199, 0, 0), visit(0, 199, 199, 398, 0, 1)),
			known_row(16'd199, 2'd1, visit(199, 0, 199, 199, 0, 1), '0),
			// equal-to-head goes below; a request past the far edge
			reg_row(sds_pkg::CFG_START_HEAD, 17'd100),
			req_row(16'd100, 1'b0),
			req_row(16'd150, 1'b0),
			req_row(16'd40, 1'b0),
			req_row(16'd300, 1'b0),
			req_row(16'd100, 1'b1),
			// nothing above the head
			req_row(16'd5, 1'b0),
			req_row(16'd100, 1'b1),
			// zero track count puts the far edge at 0
			reg_row(sds_pkg::CFG_TRACK_COUNT, 17'd0),
			reg_row(sds_pkg::CFG_START_HEAD, 17'hFFFF),
			known_row(16'hFFFF, 2'd2, visit(0, 65535, 65535, 65535, 0, 0),
				visit(65535, 0, 65535, 131070, 0, 1)),
			// oversized track count saturates the edge
			reg_row(sds_pkg::CFG_TRACK_COUNT, 17'h1FFFF),
			reg_row(sds_pkg::CFG_START_HEAD, 17'd0),
			known_row(16'hFFFF, 2'd1, visit(65535, 0, 65535, 65535, 0, 1), '0),
			reg_row(sds_pkg::CFG_TRACK_COUNT, 17'h10000),
			req_row(16'd0, 1'b0),
			req_row(16'hFFFF, 1'b0),
			req_row(16'h8000, 1'b1),
			reg_row(sds_pkg::CFG_SWEEP_UP, 17'd0),
			reg_row(sds_pkg::CFG_START_HEAD, 17'd100),
			reg_row(sds_pkg::CFG_TRACK_COUNT, 17'd200),
			known_row(16'd100, 2'd2, visit(100, 100, 0, 0, 0, 0), visit(0, 100, 100, 100, 0, 1)),
			req_row(16'd30, 1'b0),
			req_row(16'd0, 1'b0),
			req_row(16'd500, 1'b0),
			req_row(16'd150, 1'b1),
			// write to the unused index must not land anywhere
			reg_row(CFG_UNUSED, 17'h1FFFF),
			reg_row(sds_pkg::CFG_TRACK_COUNT, 17'd1),
			reg_row(sds_pkg::CFG_SWEEP_UP, 17'd1),
			known_row(16'd0, 2'd2, visit(0, 100, 100, 100, 0, 0), visit(0, 0, 0, 100, 0, 1))
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			rw = directed_rows[i];
			if (rw.is_write) begin
				settle();
				write_reg(rw.idx, rw.data);
			end else begin
				send_request(rw.item, rw.n_typed != 0);
				if (rw.n_typed != 0) expected_visits.push_back(rw.typed0);
				if (rw.n_typed == 2) expected_visits.push_back(rw.typed1);
				send_gap($urandom_range(0, 12));
			end
		end

		sent = 0;
		batch = 0;
		while (sent < RANDOM_ITEMS) begin
			if (batch == 0 || $urandom_range(0, 3) == 0) begin
				settle();
				shuffle_registers();
			end else if ($urandom_range(0, 7) == 0) begin
				settle();
			end
			if (batch == 1) len = SLOTS + 1;
			else if (batch == 4) len = SLOTS + 6;
			else begin
				case ($urandom_range(0, 11))
					0: len = $urandom_range(SLOTS + 1, SLOTS + 8);
					1, 2: len = $urandom_range(9, SLOTS);
					default: len = $urandom_range(1, 8);
				endcase
			end
			burst = ($urandom_range(0, 2) == 0);
			trk = cfg_head;
			for (k = 0; k < len; k++) begin
				trk = pick_track(trk);
				r.track = trk;
				r.last = (k == len - 1);
				send_request(r, 1'b0);
				sent++;
				if (!burst) send_gap($urandom_range(0, 12));
			end
			batch++;
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

### sim.f
rtl/core/sds_pkg.sv
rtl/core/scan_disk_scheduler.sv
bench/testbench.sv
